// ----- hdl/assert_macros.svh -----
// assertion macros used by the deframer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/ackfd_pkg.sv -----
// types and constants for the acknowledge frame deframer
`default_nettype none

package ackfd_pkg;

    localparam logic [15:0] SYNC_RESET     = 16'h1ACF;
    localparam logic [16:0] POS_MAX        = 17'h1FFFF;
    localparam logic [17:0] MIN_FRAME      = 18'd12;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd11;

    // fixed header offsets
    localparam logic [16:0] POS_SYNC_HI   = 17'd0;
    localparam logic [16:0] POS_SYNC_LO   = 17'd1;
    localparam logic [16:0] POS_IDENT_HI  = 17'd2;
    localparam logic [16:0] POS_IDENT_LO  = 17'd3;
    localparam logic [16:0] POS_LEN_HI    = 17'd6;
    localparam logic [16:0] POS_LEN_LO    = 17'd7;
    localparam logic [16:0] POS_CMD_HI    = 17'd8;
    localparam logic [16:0] POS_CMD_LO    = 17'd9;
    localparam logic [16:0] POS_PAYLOAD   = 17'd10;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_TOO_SHORT    = 3'd1,
        STATUS_BAD_SYNC     = 3'd2,
        STATUS_LEN_MISMATCH = 3'd3,
        STATUS_SUM_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic [16:0] pos;
        logic [7:0]  hold;
        logic        sync_ok;
        logic [15:0] ident;
        logic [15:0] length;
        logic [15:0] command;
        logic [15:0] sum;
        logic [15:0] check;
    } frame_state_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        status_t     status;
        logic [15:0] ident;
        logic [15:0] command;
        logic [15:0] payload_length;
    } frame_result_t;

endpackage

`default_nettype wire

// ----- hdl/ackfd_step.sv -----
// per-byte frame parsing: next frame state and result for one item
`default_nettype none

module ackfd_step (
    input  wire ackfd_pkg::frame_state_t  state,
    input  wire logic [7:0]               rx_byte,
    input  wire logic                     last_byte,
    input  wire logic [15:0]              expected_sync,
    output ackfd_pkg::frame_state_t       state_next,
    output ackfd_pkg::frame_result_t      result
);

    logic [16:0] pos;
    logic [16:0] len_ext;
    logic [16:0] pay_end;
    logic [15:0] word;
    logic [17:0] flen;
    logic        pv;
    ackfd_pkg::frame_state_t nx;

    assign pos     = state.pos;
    assign len_ext = {1'b0, state.length};
    assign pay_end = len_ext + 17'd8;
    assign word    = {state.hold, rx_byte};
    assign flen    = {1'b0, pos} + 18'd1;
    assign pv      = (pos >= ackfd_pkg::POS_PAYLOAD) && (pos <= pay_end);

    always_comb
    begin
        nx = state;

        // checksum covers the header from the identifier on, then up to the payload end
        if ((pos >= ackfd_pkg::POS_IDENT_HI) && ((pos <= ackfd_pkg::POS_LEN_LO) ||
            (pos <= pay_end)))
        begin
            nx.sum = state.sum + {8'd0, rx_byte};
        end

        case (pos) inside
            ackfd_pkg::POS_SYNC_HI, ackfd_pkg::POS_IDENT_HI,
            ackfd_pkg::POS_LEN_HI, ackfd_pkg::POS_CMD_HI:
            begin
                nx.hold = rx_byte;
            end
            ackfd_pkg::POS_SYNC_LO:
            begin
                nx.sync_ok = (word == expected_sync);
            end
            ackfd_pkg::POS_IDENT_LO:
            begin
                nx.ident = word;
            end
            ackfd_pkg::POS_LEN_LO:
            begin
                nx.length = word;
            end
            ackfd_pkg::POS_CMD_LO:
            begin
                nx.command = word;
            end
            default:
            begin
            end
        endcase

        // checksum bytes trail the payload
        if ((pos >= ackfd_pkg::POS_PAYLOAD) && (state.length != 16'd0))
        begin
            if (pos == len_ext + 17'd9)
            begin
                nx.hold = rx_byte;
            end
            else if (pos == len_ext + 17'd10)
            begin
                nx.check = word;
            end
        end

        result.payload_valid = pv;
        result.payload_byte  = pv ? rx_byte : 8'd0;
        result.frame_done    = last_byte;

        if (last_byte)
        begin
            if (flen < ackfd_pkg::MIN_FRAME)
            begin
                result.status = ackfd_pkg::STATUS_TOO_SHORT;
            end
            else if (!nx.sync_ok)
            begin
                result.status = ackfd_pkg::STATUS_BAD_SYNC;
            end
            else if ((nx.length == 16'd0) ||
                     (flen < {1'b0, {1'b0, nx.length} + ackfd_pkg::FRAME_OVERHEAD}))
            begin
                result.status = ackfd_pkg::STATUS_LEN_MISMATCH;
            end
            else if (~nx.sum != nx.check)
            begin
                result.status = ackfd_pkg::STATUS_SUM_MISMATCH;
            end
            else
            begin
                result.status = ackfd_pkg::STATUS_OK;
            end
            result.ident          = nx.ident;
            result.command        = nx.command;
            result.payload_length = (nx.length != 16'd0) ? (nx.length - 16'd1) : 16'd0;
            nx                    = '0;
        end
        else
        begin
            result.status         = ackfd_pkg::STATUS_OK;
            result.ident          = 16'd0;
            result.command        = 16'd0;
            result.payload_length = 16'd0;
            if (pos < ackfd_pkg::POS_MAX)
            begin
                nx.pos = pos + 17'd1;
            end
        end

        state_next = nx;
    end

endmodule

`default_nettype wire

// ----- hdl/ack_frame_deframer_top.sv -----
// result: each accepted byte's result item is registered and valid in the next cycle
// throughput: one byte per cycle; in_ready drops only while a result waits on out_ready
// the frame state and a single output register are the only pipeline storage
// reset: expected sync word returns to 0x1ACF, frame state and output valid clear
`default_nettype none

`include "assert_macros.svh"

module ack_frame_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic             frame_done,
    output logic [2:0]       frame_status,
    output logic [15:0]      packet_ident,
    output logic [15:0]      command_word,
    output logic [15:0]      payload_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]               sync_reg;
    ackfd_pkg::frame_state_t   state_reg;
    ackfd_pkg::frame_state_t   state_next;
    ackfd_pkg::frame_result_t  result_reg;
    ackfd_pkg::frame_result_t  result_next;
    logic                      out_valid_reg;
    logic                      in_fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    ackfd_step u_step (
        .state         (state_reg),
        .rx_byte       (rx_byte),
        .last_byte     (last_byte),
        .expected_sync (sync_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= ackfd_pkg::SYNC_RESET;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sync_reg <= cfg_data;
            end
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_valid  = result_reg.payload_valid;
    assign payload_byte   = result_reg.payload_byte;
    assign frame_done     = result_reg.frame_done;
    assign frame_status   = result_reg.status;
    assign packet_ident   = result_reg.ident;
    assign command_word   = result_reg.command;
    assign payload_length = result_reg.payload_length;

    `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid_reg, in_ready)
    `ASSERT_NEXT(a_pos_clear_after_last, clk, rst_n, in_fire && last_byte, state_reg.pos == 17'd0)
    `ASSERT_IMPL(a_mid_frame_zero, clk, rst_n, out_valid_reg && !result_reg.frame_done, (result_reg.status == ackfd_pkg::STATUS_OK) && (result_reg.ident == 16'd0) && (result_reg.payload_length == 16'd0))
    `ASSERT_IMPL(a_payload_gated, clk, rst_n, out_valid_reg && !result_reg.payload_valid, result_reg.payload_byte == 8'd0)

endmodule

`default_nettype wire

// ----- tb/ack_frame_deframer_top_tb.sv -----
// testbench for ack_frame_deframer_top: directed and random frames checked byte by byte
module ack_frame_deframer_top_tb;

    localparam int STUCK_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 300;
    localparam int SEND_IDLE [4] = '{0, 66, 0, 37};
    localparam int RECV_STALL [4] = '{0, 0, 66, 37};

    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC,
        FR_BAD_SUM,
        FR_TRUNC,
        FR_ZERO_LEN,
        FR_RUNT,
        FR_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic [7:0]          data;
        logic                last;
        logic                typed;
        ackfd_pkg::status_t  status;
        logic [15:0]         ident;
        logic [15:0]         command;
        logic [15:0]         plen;
    } wire_item_t;

    // too short, then a good frame with a length field of one and no payload, then a zero-length frame
    localparam wire_item_t DIRECTED_BYTES [25] = '{
        '{8'h5A, 1'b1, 1'b1, ackfd_pkg::STATUS_TOO_SHORT, 16'h0000, 16'h0000, 16'h0000},
        '{8'h1A, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hCF, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h01, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFC, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h02, 1'b1, 1'b1, ackfd_pkg::STATUS_OK, 16'hFFFF, 16'hFFFF, 16'h0000},
        '{8'h1A, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hCF, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h12, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h34, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h7F, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hAB, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'hCD, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, ackfd_pkg::STATUS_OK, 16'h0000, 16'h0000, 16'h0000},
        '{8'h55, 1'b1, 1'b1, ackfd_pkg::STATUS_LEN_MISMATCH, 16'h1234, 16'hABCD, 16'h0000}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [15:0] packet_ident;
    logic [15:0] command_word;
    logic [15:0] payload_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    wire_item_t               wire_bytes [$];
    wire_item_t               cur_item;
    ackfd_pkg::frame_result_t frame_results_due [$];
    ackfd_pkg::frame_state_t  rx_state = '0;
    logic [15:0]              sync_word = ackfd_pkg::SYNC_RESET;
    int                       send_idle_pct = 0;
    int                       rx_stall_pct = 0;
    bit                       long_hold_req = 1'b0;
    int                       stuck_cycles = 0;
    int                       mismatches = 0;

    ack_frame_deframer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .frame_done     (frame_done),
        .frame_status   (frame_status),
        .packet_ident   (packet_ident),
        .command_word   (command_word),
        .payload_length (payload_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ackfd_pkg::frame_result_t deframe_byte(input logic [7:0] b,
                                                              input logic last);
        ackfd_pkg::frame_result_t r;
        int unsigned   p;
        int unsigned   len;
        int unsigned   flen;
        logic [15:0]   word;
        r = '0;
        p = rx_state.pos;
        len = rx_state.length;
        word = {rx_state.hold, b};
        if (p >= ackfd_pkg::POS_IDENT_HI &&
            (p <= ackfd_pkg::POS_LEN_LO || p <= ackfd_pkg::POS_CMD_HI + len))
            rx_state.sum = rx_state.sum + b;
        case (p)
            ackfd_pkg::POS_SYNC_HI, ackfd_pkg::POS_IDENT_HI,
            ackfd_pkg::POS_LEN_HI, ackfd_pkg::POS_CMD_HI: rx_state.hold = b;
            ackfd_pkg::POS_SYNC_LO:  rx_state.sync_ok = (word == sync_word);
            ackfd_pkg::POS_IDENT_LO: rx_state.ident = word;
            ackfd_pkg::POS_LEN_LO:   rx_state.length = word;
            ackfd_pkg::POS_CMD_LO:   rx_state.command = word;
            default: ;
        endcase
        if (p >= ackfd_pkg::POS_PAYLOAD && len >= 1)
        begin
            if (p == ackfd_pkg::POS_CMD_LO + len)
                rx_state.hold = b;
            else if (p == ackfd_pkg::POS_PAYLOAD + len)
                rx_state.check = word;
        end
        r.payload_valid = (p >= ackfd_pkg::POS_PAYLOAD && p <= ackfd_pkg::POS_CMD_HI + len);
        r.payload_byte = r.payload_valid ? b : 8'h00;
        r.frame_done = last;
        if (last)
        begin
            flen = p + 1;
            if (flen < ackfd_pkg::MIN_FRAME)
                r.status = ackfd_pkg::STATUS_TOO_SHORT;
            else if (!rx_state.sync_ok)
                r.status = ackfd_pkg::STATUS_BAD_SYNC;
            else if (rx_state.length == 0 ||
                     flen < rx_state.length + ackfd_pkg::FRAME_OVERHEAD)
                r.status = ackfd_pkg::STATUS_LEN_MISMATCH;
            else if (~rx_state.sum != rx_state.check)
                r.status = ackfd_pkg::STATUS_SUM_MISMATCH;
            else
                r.status = ackfd_pkg::STATUS_OK;
            r.ident = rx_state.ident;
            r.command = rx_state.command;
            r.payload_length = (rx_state.length >= 1) ? rx_state.length - 16'd1 : 16'h0000;
            rx_state = '0;
        end
        else if (rx_state.pos < ackfd_pkg::POS_MAX)
        begin
            rx_state.pos = rx_state.pos + 17'd1;
        end
        return r;
    endfunction

    function automatic int queue_frame(input frame_kind_t kind, input int unsigned ln,
                                       input int unsigned pad);
        logic [7:0]  f [$];
        logic [15:0] sync;
        logic [15:0] sum;
        logic [15:0] cks;
        int unsigned cut;
        int          n;
        wire_item_t  it;
        sync = sync_word;
        cut = 32'hFFFF_FFFF;
        if (kind == FR_BAD_SYNC)
            sync = sync ^ (16'h0001 << $urandom_range(15));
        if (kind == FR_ZERO_LEN)
            ln = 0;
        if (kind == FR_TRUNC)
        begin
            if ($urandom_range(1) == 1)
                ln = $urandom_range(65535, 1);
            cut = $urandom_range((ln + 10 > 60) ? 60 : ln + 10, 1);
        end
        f.push_back(sync[15:8]);
        f.push_back(sync[7:0]);
        repeat (4) f.push_back(8'($urandom_range(255)));
        f.push_back(ln[15:8]);
        f.push_back(ln[7:0]);
        repeat (2) f.push_back(8'($urandom_range(255)));
        while (f.size() < 9 + ln && f.size() < cut)
            f.push_back(8'($urandom_range(255)));
        sum = '0;
        for (int i = 2; i < f.size(); i++)
            sum = sum + f[i];
        cks = ~sum;
        if (kind == FR_BAD_SUM)
            cks = cks ^ 16'($urandom_range(65535, 1));
        f.push_back(cks[15:8]);
        f.push_back(cks[7:0]);
        repeat (pad) f.push_back(8'($urandom_range(255)));
        n = f.size();
        case (kind)
            FR_TRUNC: n = cut;
            FR_RUNT:  n = $urandom_range(11, 1);
            FR_NOISE: n = $urandom_range(f.size(), 1);
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            it = '0;
            it.data = (kind == FR_NOISE) ? 8'($urandom_range(255)) : f[i];
            it.last = (i == n - 1);
            wire_bytes.push_back(it);
        end
        return n;
    endfunction

    function automatic int queue_random_frame();
        int unsigned pick;
        int unsigned ln;
        int unsigned pad;
        frame_kind_t kind;
        pick = $urandom_range(99);
        if (pick < 55)
            kind = FR_GOOD;
        else if (pick < 65)
            kind = FR_BAD_SYNC;
        else if (pick < 75)
            kind = FR_BAD_SUM;
        else if (pick < 83)
            kind = FR_TRUNC;
        else if (pick < 88)
            kind = FR_ZERO_LEN;
        else if (pick < 94)
            kind = FR_RUNT;
        else
            kind = FR_NOISE;
        ln = ($urandom_range(39) == 0) ? $urandom_range(300, 1) : $urandom_range(16, 1);
        pad = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
        return queue_frame(kind, ln, pad);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic wait_drained();
        while (wire_bytes.size() != 0 || in_valid || frame_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_sync(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sync_word = value;
    endtask

    always @(posedge clk)
    begin : sender
        ackfd_pkg::frame_result_t r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                r = deframe_byte(rx_byte, last_byte);
                if (cur_item.typed)
                begin
                    r.payload_valid = 1'b0;
                    r.payload_byte = 8'h00;
                    r.frame_done = 1'b1;
                    r.status = cur_item.status;
                    r.ident = cur_item.ident;
                    r.command = cur_item.command;
                    r.payload_length = cur_item.plen;
                end
                frame_results_due.push_back(r);
            end
            if (!in_valid || in_ready)
            begin
                if (wire_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = wire_bytes.pop_front();
                    in_valid <= 1'b1;
                    rx_byte <= cur_item.data;
                    last_byte <= cur_item.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        ackfd_pkg::frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("result item with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                check_field("payload_valid", want.payload_valid, payload_valid);
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("frame_done", want.frame_done, frame_done);
                check_field("frame_status", want.status, frame_status);
                check_field("packet_ident", want.ident, packet_ident);
                check_field("command_word", want.command, command_word);
                check_field("payload_length", want.payload_length, payload_length);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[ack_frame_deframer_top] ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : main
        logic [15:0] phase_sync;
        int          queued;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_BYTES[i])
            wire_bytes.push_back(DIRECTED_BYTES[i]);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: phase_sync = 16'h0000;
                1: phase_sync = 16'hFFFF;
                2: phase_sync = 16'($urandom_range(65535));
                default: phase_sync = ackfd_pkg::SYNC_RESET;
            endcase
            write_sync(phase_sync);
            send_idle_pct = SEND_IDLE[ph];
            rx_stall_pct = RECV_STALL[ph];
            if (ph == 0)
            begin
                // long frame with trailing bytes after the checksum, sent into a long stall
                void'(queue_frame(FR_GOOD, 48, 4));
                long_hold_req = 1'b1;
            end
            queued = 0;
            while (queued < PHASE_ITEMS)
                queued += queue_random_frame();
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ack_frame_deframer_top] OK");
        else
            $display("[ack_frame_deframer_top] ERROR");
        $finish;
    end
endmodule
